// File: rtl/gfs_pkg.sv
// Package for the format specification parser: payload structs, status codes
// and the character constants that the phase decisions compare against.
// No dependencies; the interfaces and the top level import it.
package gfs_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_PENDING = 2'd0;
  localparam status_t ST_OK      = 2'd1;
  localparam status_t ST_UNKNOWN = 2'd2;
  localparam status_t ST_END     = 2'd3;

  localparam logic [7:0] CH_L       = 8'h4C;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_M       = 8'h4D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic       byte_handed_back;
    logic       trailing_zeros;
    logic       incremental_mode;
    logic [7:0] x_integer_digits;
    logic [7:0] x_decimal_digits;
    logic [7:0] y_integer_digits;
    logic [7:0] y_decimal_digits;
  } out_item_t;

endpackage

// File: rtl/gfs_in_if.sv
// Input channel of the parser: one text byte or an end-of-data mark per transfer.
// Depends on gfs_pkg for the payload struct.
interface gfs_in_if;
  import gfs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/gfs_out_if.sv
// Result channel of the parser: status, handed-back flag and parsed fields.
// Depends on gfs_pkg for the payload struct.
interface gfs_out_if;
  import gfs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/gerber_format_spec_parser.sv
// Top level of the format specification parser: phase register, parsed fields
// and the result register. Depends on gfs_pkg, gfs_in_if and gfs_out_if.
//
//   channel  direction  payload per transfer
//   req      in         byte_value, end_of_data
//   rsp      out        status, byte_handed_back, mode flags, four digit counts
//
// Each byte passes through the phase decision, which sits between the parse state
// and the result register; one byte is taken every cycle while rsp is not stalled.
// A result is registered and appears in the cycle after its byte is transferred.
// req.ready is high whenever the result register is empty or is being taken,
// so a stalled rsp holds the result and stops new bytes after one.
// Reset (rst, synchronous) returns to the zero mode phase and clears the fields.
module gerber_format_spec_parser (
  input  logic       clk,
  input  logic       rst,
  gfs_in_if.sink     req,
  gfs_out_if.source  rsp
);
  import gfs_pkg::*;

  typedef enum logic [3:0] {
    PH_ZERO_MODE  = 4'd0,
    PH_COORD_MODE = 4'd1,
    PH_SKIP_NG    = 4'd2,
    PH_X_INT      = 4'd3,
    PH_X_DEC      = 4'd4,
    PH_EXPECT_Y   = 4'd5,
    PH_Y_INT      = 4'd6,
    PH_Y_DEC      = 4'd7,
    PH_SKIP_DM    = 4'd8,
    PH_PERCENT    = 4'd9
  } phase_t;

  phase_t     phase, phase_next;
  logic       zero_mode, zero_mode_next;
  logic       coord_mode, coord_mode_next;
  logic [7:0] x_int, x_int_next;
  logic [7:0] x_dec, x_dec_next;
  logic [7:0] y_int, y_int_next;
  logic [7:0] y_dec, y_dec_next;
  status_t    status_next;
  logic       back_next;

  logic       out_valid;
  out_item_t  out_data;
  logic       accept;
  logic [7:0] b;
  logic [7:0] digit;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign b         = req.data.byte_value;
  assign digit     = b - CH_ZERO;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    phase_next      = phase;
    zero_mode_next  = zero_mode;
    coord_mode_next = coord_mode;
    x_int_next      = x_int;
    x_dec_next      = x_dec;
    y_int_next      = y_int;
    y_dec_next      = y_dec;
    status_next     = ST_PENDING;
    back_next       = 1'b0;

    if (req.data.end_of_data) begin
      status_next = ST_END;
    end else begin
      case (phase)
        PH_COORD_MODE: begin
          if (b == CH_A) begin
            coord_mode_next = 1'b0;
            phase_next      = PH_SKIP_NG;
          end else if (b == CH_I) begin
            coord_mode_next = 1'b1;
            phase_next      = PH_SKIP_NG;
          end else begin
            status_next = ST_UNKNOWN;
          end
        end
        PH_SKIP_NG: begin
          if (b == CH_X) begin
            phase_next = PH_X_INT;
          end else if (b != CH_N && b != CH_G) begin
            status_next = ST_UNKNOWN;
          end
        end
        PH_X_INT: begin
          x_int_next = digit;
          phase_next = PH_X_DEC;
        end
        PH_X_DEC: begin
          x_dec_next = digit;
          phase_next = PH_EXPECT_Y;
        end
        PH_EXPECT_Y: begin
          if (b == CH_Y) begin
            phase_next = PH_Y_INT;
          end else begin
            status_next = ST_UNKNOWN;
          end
        end
        PH_Y_INT: begin
          y_int_next = digit;
          phase_next = PH_Y_DEC;
        end
        PH_Y_DEC: begin
          y_dec_next = digit;
          phase_next = PH_SKIP_DM;
        end
        PH_SKIP_DM: begin
          if (b == CH_STAR) begin
            phase_next = PH_PERCENT;
          end else if (b != CH_D && b != CH_M) begin
            status_next = ST_UNKNOWN;
          end
        end
        PH_PERCENT: begin
          if (b == CH_PERCENT) begin
            status_next = ST_OK;
          end else begin
            // A missing percent leaves the byte for the caller.
            status_next = ST_UNKNOWN;
            back_next   = 1'b1;
          end
        end
        default: begin
          if (b == CH_L) begin
            zero_mode_next = 1'b0;
            phase_next     = PH_COORD_MODE;
          end else if (b == CH_T) begin
            zero_mode_next = 1'b1;
            phase_next     = PH_COORD_MODE;
          end else begin
            status_next = ST_UNKNOWN;
          end
        end
      endcase
    end

    if (status_next != ST_PENDING) begin
      phase_next = PH_ZERO_MODE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ZERO_MODE;
      zero_mode  <= 1'b0;
      coord_mode <= 1'b0;
      x_int      <= '0;
      x_dec      <= '0;
      y_int      <= '0;
      y_dec      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        zero_mode  <= zero_mode_next;
        coord_mode <= coord_mode_next;
        x_int      <= x_int_next;
        x_dec      <= x_dec_next;
        y_int      <= y_int_next;
        y_dec      <= y_dec_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.status           <= status_next;
      out_data.byte_handed_back <= back_next;
      out_data.trailing_zeros   <= zero_mode_next;
      out_data.incremental_mode <= coord_mode_next;
      out_data.x_integer_digits <= x_int_next;
      out_data.x_decimal_digits <= x_dec_next;
      out_data.y_integer_digits <= y_int_next;
      out_data.y_decimal_digits <= y_dec_next;
    end
  end

  a_accept_fills_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && req.data.end_of_data |=> phase == PH_ZERO_MODE && out_data.status == ST_END)
    else $error("end of data did not restart the parse");

  a_handback_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_handed_back |-> out_data.status == ST_UNKNOWN)
    else $error("handed-back byte without unknown format status");

  a_ok_from_percent: assert property (@(posedge clk) disable iff (rst)
    accept && !req.data.end_of_data && phase == PH_PERCENT && b == CH_PERCENT
      |=> out_data.status == ST_OK && phase == PH_ZERO_MODE)
    else $error("closing percent did not complete the parse");

  a_pending_keeps_phase_live: assert property (@(posedge clk) disable iff (rst)
    accept && status_next == ST_PENDING |-> phase_next != PH_ZERO_MODE)
    else $error("pending status left the parser in its first phase");

endmodule
